### design/bpc_pkg.sv
`timescale 1ns / 1ps
package bpc_pkg;

  localparam int WordCount = 8;
  localparam int WordWidth = 16;
  localparam int RawWidth  = 24;
  localparam int OutWidth  = 32;
  localparam logic [15:0] CrcPoly = 16'h3000;
  localparam logic [15:0] CrcKeep = 16'hFF00;
  localparam logic signed [OutWidth-1:0] TempBase = 32'sd2000;

  // serial multiplier widths: 24-bit unsigned times signed value of up to 42 bits
  localparam int MulAWidth = 25;
  localparam int MulBWidth = 42;
  localparam int MulPWidth = MulAWidth + MulBWidth;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_COMP = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [0:0]  opcode;
    logic [2:0]  word_index;
    logic [15:0] prom_word;
    logic [23:0] press_adc;
    logic [23:0] temp_adc;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         crc_computed;
    logic               crc_match;
    logic signed [31:0] pressure_centi;
    logic signed [31:0] temperature_centi;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CRC,
    ST_M_OFF,
    ST_W_OFF,
    ST_M_SENS,
    ST_W_SENS,
    ST_M_TEMP,
    ST_W_TEMP,
    ST_M_P,
    ST_W_P,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } mul_ctl_t;

endpackage

### design/bpc_serial_mul.sv
`timescale 1ns / 1ps
module bpc_serial_mul (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  bpc_pkg::mul_ctl_t                       ctl,
  input  logic [bpc_pkg::MulAWidth-1:0]           mul_a,
  input  logic signed [bpc_pkg::MulBWidth-1:0]    mul_b,
  output logic                                    done,
  output logic signed [bpc_pkg::MulPWidth-1:0]    product
);
  import bpc_pkg::*;

  localparam int CntWidth = $clog2(MulAWidth + 1);

  logic [MulAWidth-1:0]        a_r, a_nxt;
  logic signed [MulPWidth-1:0] acc_r, acc_nxt;
  logic signed [MulPWidth-1:0] b_sh_r, b_sh_nxt;
  logic [CntWidth-1:0]         cnt_r, cnt_nxt;
  logic                        run_r, run_nxt;
  logic                        done_r, done_nxt;

  // shift-and-add, one multiplier bit per cycle, multiplier a is unsigned
  always_comb begin
    a_nxt    = a_r;
    acc_nxt  = acc_r;
    b_sh_nxt = b_sh_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      a_nxt    = mul_a;
      acc_nxt  = '0;
      b_sh_nxt = MulPWidth'(mul_b);
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (a_r[0]) acc_nxt = acc_r + b_sh_r;
      a_nxt    = a_r >> 1;
      b_sh_nxt = b_sh_r <<< 1;
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CntWidth'(MulAWidth - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    acc_r  <= acc_nxt;
    b_sh_r <= b_sh_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done    = done_r;
  assign product = acc_r;
endmodule

### design/baro_prom_crc_and_compensation_unit.sv
`timescale 1ns / 1ps
// load request: the result follows a crc walk over 128 bits
// compensate request: crc walk then four serial multiplies
// one request in flight at a time; in_ready returns the cycle after the result is taken
// out_valid holds until out_ready; the next request is taken when the result is gone
// reset (rst_n, synchronous) clears the calibration store, state machine and handshake
module baro_prom_crc_and_compensation_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bpc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bpc_pkg::out_item_t  out_data
);
  import bpc_pkg::*;

  logic [WordWidth-1:0] store_r [WordCount];
  state_t     state_r, state_nxt;
  in_item_t   item_r;
  logic [6:0] bit_r, bit_nxt;
  logic [15:0] rem_r, rem_nxt;
  out_item_t  res_r, res_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic signed [25:0] dt_r, dt_nxt;
  logic signed [41:0] off_r, off_nxt;
  logic signed [41:0] sens_r, sens_nxt;
  logic signed [31:0] temp_r, temp_nxt;
  logic       in_fire;

  mul_ctl_t   mctl;
  logic [MulAWidth-1:0]        mul_a;
  logic signed [MulBWidth-1:0] mul_b;
  logic                        mul_done;
  logic signed [MulPWidth-1:0] mul_p;

  logic [15:0] crc_word;
  logic        crc_bit;
  logic [15:0] rem_x;

  assign in_ready = (state_r == ST_IDLE) && !out_valid_r;
  assign in_fire  = in_valid && in_ready;

  // store write on a load request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WordCount; i++) store_r[i] <= '0;
    end else if (in_fire && in_data.opcode == OP_LOAD) begin
      store_r[in_data.word_index] <= in_data.prom_word;
    end
  end

  // crc data bit, high byte first, word 7 low byte forced to zero
  // each byte enters the remainder at its low byte, so a data bit goes in at bit 7
  always_comb begin
    crc_word = store_r[bit_r[6:4]];
    if (bit_r[6:4] == 3'd7) crc_word = crc_word & CrcKeep;
    crc_bit = crc_word[4'd15 - bit_r[3:0]];
    rem_x   = rem_r ^ {8'd0, crc_bit, 7'd0};
    if (rem_x[15]) rem_nxt = {rem_x[14:0], 1'b0} ^ CrcPoly;
    else           rem_nxt = {rem_x[14:0], 1'b0};
  end

  bpc_serial_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mctl),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  // sequencer: crc walk, then for compensate requests off, sens, temp and pressure products
  always_comb begin
    state_nxt     = state_r;
    bit_nxt       = bit_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    dt_nxt        = dt_r;
    off_nxt       = off_r;
    sens_nxt      = sens_r;
    temp_nxt      = temp_r;
    mctl          = '0;
    mul_a         = '0;
    mul_b         = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          bit_nxt   = '0;
          state_nxt = ST_CRC;
        end
      end
      ST_CRC: begin
        bit_nxt = bit_r + 1'b1;
        if (bit_r == 7'd127) begin
          res_nxt.crc_computed = rem_nxt[15:12];
          res_nxt.crc_match    = (rem_nxt[15:12] == store_r[7][3:0]);
          res_nxt.pressure_centi    = '0;
          res_nxt.temperature_centi = '0;
          dt_nxt = $signed({2'b00, item_r.temp_adc})
                   - $signed({2'b00, store_r[5], 8'd0});
          if (item_r.opcode == OP_COMP) state_nxt = ST_M_OFF;
          else                          state_nxt = ST_OUT;
        end
      end
      ST_M_OFF: begin
        mctl.start = 1'b1;
        mul_a = MulAWidth'({1'b0, store_r[4]});
        mul_b = MulBWidth'(dt_r);
        state_nxt = ST_W_OFF;
      end
      ST_W_OFF: begin
        mctl.busy = 1'b1;
        if (mul_done) begin
          off_nxt = $signed({9'd0, store_r[2], 17'd0}) + MulBWidth'(mul_p >>> 6);
          state_nxt = ST_M_SENS;
        end
      end
      ST_M_SENS: begin
        mctl.start = 1'b1;
        mul_a = MulAWidth'({1'b0, store_r[3]});
        mul_b = MulBWidth'(dt_r);
        state_nxt = ST_W_SENS;
      end
      ST_W_SENS: begin
        mctl.busy = 1'b1;
        if (mul_done) begin
          sens_nxt = $signed({10'd0, store_r[1], 16'd0}) + MulBWidth'(mul_p >>> 7);
          state_nxt = ST_M_TEMP;
        end
      end
      ST_M_TEMP: begin
        mctl.start = 1'b1;
        mul_a = MulAWidth'({1'b0, store_r[6]});
        mul_b = MulBWidth'(dt_r);
        state_nxt = ST_W_TEMP;
      end
      ST_W_TEMP: begin
        mctl.busy = 1'b1;
        if (mul_done) begin
          temp_nxt = TempBase + OutWidth'(mul_p >>> 23);
          state_nxt = ST_M_P;
        end
      end
      ST_M_P: begin
        mctl.start = 1'b1;
        mul_a = MulAWidth'({1'b0, item_r.press_adc});
        mul_b = sens_r;
        state_nxt = ST_W_P;
      end
      ST_W_P: begin
        mctl.busy = 1'b1;
        if (mul_done) begin
          res_nxt.pressure_centi =
            OutWidth'(((mul_p >>> 21) - MulPWidth'(off_r)) >>> 15);
          res_nxt.temperature_centi = temp_r;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    bit_r  <= bit_nxt;
    res_r  <= res_nxt;
    dt_r   <= dt_nxt;
    off_r  <= off_nxt;
    sens_r <= sens_nxt;
    temp_r <= temp_nxt;
    if (in_fire) item_r <= in_data;
    if (state_r == ST_IDLE) rem_r <= '0;
    else if (state_r == ST_CRC) rem_r <= rem_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready) else $error("request taken while busy");
  a_out_after_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT) else $error("result without sequence");
  a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && item_r.opcode == OP_LOAD) |->
      (res_r.pressure_centi == 0 && res_r.temperature_centi == 0))
    else $error("load result not zero");
endmodule
